// File: rtl/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg - shared types and constants of the size-class chunk allocator
// Field widths, status codes, class sizes and the request and response
// payload structures used by the channel interfaces and the sequencer.
// ----------------------------------------------------------------------------
package sca_pkg;

    // Fixed field widths
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int SPARE_W  = 6;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 3;

    // Region geometry
    localparam int DEF_PAGES      = 64;
    localparam int CLASSES        = 8;
    localparam int PAGE_SHIFT     = 12;   // 4096-byte pages
    localparam int SLOT_SHIFT     = 4;    // 16-byte slots
    localparam int OFFS_W         = PAGE_SHIFT - SLOT_SHIFT;

    // Owner table entry: valid flag over class index
    localparam int OWN_W = CLASS_W + 1;
    localparam logic [OWN_W-1:0] OWNER_NONE = '0;

    // Chunk size of each class in bytes
    localparam logic [11:0] CLASS_BYTES [CLASSES] = '{
        12'd16, 12'd32, 12'd64, 12'd128, 12'd256, 12'd512, 12'd1024, 12'd2048
    };

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_FREED     = 3'd1,
        ST_ZERO_SIZE = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_NO_PAGE   = 3'd4,
        ST_NOT_POOL  = 3'd5
    } status_t;

    typedef struct packed {
        logic               action;
        logic [SIZE_W-1:0]  request_size;
        logic [ADDR_W-1:0]  free_address;
        logic [SPARE_W-1:0] spare_page;
        logic               spare_valid;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  chunk_address;
        logic               page_taken;
        logic [CLASS_W-1:0] size_class;
    } rsp_t;

endpackage

// File: rtl/sca_if.sv
// ----------------------------------------------------------------------------
// sca_if - request and response channels of the chunk allocator
// Valid/ready channels; a transfer takes place on a rising clock edge at
// which valid and ready are both high.
// ----------------------------------------------------------------------------
interface sca_req_if;
    logic          valid;
    logic          ready;
    sca_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sca_rsp_if;
    logic          valid;
    logic          ready;
    sca_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/sca_ram.sv
// ----------------------------------------------------------------------------
// sca_ram - simple dual-port synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module sca_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sca_ctrl.sv
// ----------------------------------------------------------------------------
// sca_ctrl - allocator sequencer
// Holds the class list heads, clears the page owner table after reset,
// decodes requests, pops and pushes chunks through the link RAM and slices
// a spare page into chunks on a refill.
// ----------------------------------------------------------------------------
module sca_ctrl #(
    parameter int PAGES = sca_pkg::DEF_PAGES,
    parameter int PW    = (PAGES > 1) ? $clog2(PAGES) : 1,
    parameter int SW    = PW + sca_pkg::OFFS_W,
    parameter int LW    = SW + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [sca_pkg::ADDR_W-1:0] cfg_wr_data,
    // request side
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sca_pkg::req_t              in_data,
    // result side
    output logic                       res_valid,
    input  logic                       res_ready,
    output sca_pkg::rsp_t              res_data,
    // chunk link RAM
    output logic                       link_wr_en,
    output logic [SW-1:0]              link_wr_addr,
    output logic [LW-1:0]              link_wr_data,
    output logic                       link_rd_en,
    output logic [SW-1:0]              link_rd_addr,
    input  logic [LW-1:0]              link_rd_data,
    // page owner RAM
    output logic                       owner_wr_en,
    output logic [PW-1:0]              owner_wr_addr,
    output logic [sca_pkg::OWN_W-1:0]  owner_wr_data,
    output logic                       owner_rd_en,
    output logic [PW-1:0]              owner_rd_addr,
    input  logic [sca_pkg::OWN_W-1:0]  owner_rd_data
);

    localparam int ADDR_W  = sca_pkg::ADDR_W;
    localparam int CLASS_W = sca_pkg::CLASS_W;
    localparam int OFFS_W  = sca_pkg::OFFS_W;
    localparam int HI_W    = ADDR_W - sca_pkg::PAGE_SHIFT;
    localparam logic [LW-1:0] HEAD_EMPTY = {1'b1, {SW{1'b0}}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_POP_WAIT,
        S_OWN_WAIT,
        S_FILL,
        S_RESULT
    } state_t;

    state_t                 state_reg;
    logic [PW-1:0]          clr_cnt_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [LW-1:0]          head_reg [sca_pkg::CLASSES];
    sca_pkg::req_t          in_reg;
    logic [CLASS_W-1:0]     cls_reg;
    logic [PW-1:0]          page_reg;
    logic [SW-1:0]          slot_reg;
    logic [LW-1:0]          cur_reg;
    logic [OFFS_W-1:0]      fill_cnt_reg;
    sca_pkg::rsp_t          res_reg;

    logic [CLASS_W-1:0]     cls_dec;
    logic                   size_zero;
    logic                   size_big;
    logic                   spare_ok;
    logic [PW-1:0]          spare_idx;
    logic [ADDR_W-1:0]      free_off;
    logic                   free_out;
    logic [PW-1:0]          free_page;
    logic [SW-1:0]          free_slot;
    logic [CLASS_W-1:0]     owner_cls;
    logic                   owner_valid;
    logic [CLASS_W-1:0]     head_idx;
    logic [LW-1:0]          head_sel;
    logic [OFFS_W-1:0]      fill_off;
    logic [SW-1:0]          fill_slot;
    logic                   fill_last;
    logic [ADDR_W-1:0]      pop_addr;
    logic [ADDR_W-1:0]      fill_addr;

    // Size class: smallest class that holds the request
    always_comb
    begin
        cls_dec = CLASS_W'(sca_pkg::CLASSES - 1);
        for (int c = sca_pkg::CLASSES - 1; c >= 0; c--)
        begin
            if (in_reg.request_size <= 32'(sca_pkg::CLASS_BYTES[c]))
            begin
                cls_dec = CLASS_W'(c);
            end
        end
    end

    assign size_zero = (in_reg.request_size == '0);
    assign size_big  = (in_reg.request_size >
                        32'(sca_pkg::CLASS_BYTES[sca_pkg::CLASSES - 1]));
    assign spare_ok  = in_reg.spare_valid && (32'(in_reg.spare_page) < 32'(PAGES));
    assign spare_idx = PW'(in_reg.spare_page);

    // Free address decode, offset wraps modulo the address width
    assign free_off  = in_reg.free_address - base_reg;
    assign free_out  = (free_off[ADDR_W-1:sca_pkg::PAGE_SHIFT] >= HI_W'(PAGES));
    assign free_page = free_off[PW+sca_pkg::PAGE_SHIFT-1:sca_pkg::PAGE_SHIFT];
    assign free_slot = free_off[SW+sca_pkg::SLOT_SHIFT-1:sca_pkg::SLOT_SHIFT];

    assign owner_cls   = owner_rd_data[CLASS_W-1:0];
    assign owner_valid = owner_rd_data[CLASS_W];

    // Single read port on the list heads
    assign head_idx = (state_reg == S_OWN_WAIT) ? owner_cls : cls_dec;
    assign head_sel = head_reg[head_idx];

    // Refill slicing: chunk i sits at slot i << class within the page
    assign fill_off  = OFFS_W'(fill_cnt_reg << cls_reg);
    assign fill_slot = {page_reg, fill_off};
    assign fill_last = (fill_cnt_reg == ({OFFS_W{1'b1}} >> cls_reg));

    assign pop_addr  = base_reg + ADDR_W'({cur_reg[SW-1:0], 4'b0000});
    assign fill_addr = base_reg + ADDR_W'({fill_slot, 4'b0000});

    // Link RAM access
    always_comb
    begin
        link_wr_en   = 1'b0;
        link_wr_addr = fill_slot;
        link_wr_data = cur_reg;
        link_rd_en   = 1'b0;
        link_rd_addr = head_sel[SW-1:0];
        case (state_reg)
            S_FILL:
            begin
                link_wr_en = 1'b1;
            end
            S_OWN_WAIT:
            begin
                link_wr_en   = owner_valid;
                link_wr_addr = slot_reg;
                link_wr_data = head_sel;
            end
            S_DECODE:
            begin
                link_rd_en = (in_reg.action == sca_pkg::ACT_ALLOC) && !size_zero &&
                             !size_big && !head_sel[LW-1];
            end
            default:
            begin
                link_wr_en = 1'b0;
            end
        endcase
    end

    // Owner RAM access: clearing sweep, refill claim, free lookup
    always_comb
    begin
        owner_wr_en   = 1'b0;
        owner_wr_addr = spare_idx;
        owner_wr_data = {1'b1, cls_dec};
        owner_rd_en   = 1'b0;
        owner_rd_addr = free_page;
        case (state_reg)
            S_CLEAR:
            begin
                owner_wr_en   = 1'b1;
                owner_wr_addr = clr_cnt_reg;
                owner_wr_data = sca_pkg::OWNER_NONE;
            end
            S_DECODE:
            begin
                if (in_reg.action == sca_pkg::ACT_FREE)
                begin
                    owner_rd_en = !free_out;
                end
                else
                begin
                    owner_wr_en = !size_zero && !size_big && head_sel[LW-1] && spare_ok;
                end
            end
            default:
            begin
                owner_wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            base_reg     <= '0;
            in_reg       <= '0;
            cls_reg      <= '0;
            page_reg     <= '0;
            slot_reg     <= '0;
            cur_reg      <= HEAD_EMPTY;
            fill_cnt_reg <= '0;
            res_reg      <= '0;
            for (int i = 0; i < sca_pkg::CLASSES; i++)
            begin
                head_reg[i] <= HEAD_EMPTY;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_cnt_reg == PW'(PAGES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_reg    <= in_data;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    cls_reg      <= cls_dec;
                    page_reg     <= spare_idx;
                    slot_reg     <= free_slot;
                    cur_reg      <= head_sel;
                    fill_cnt_reg <= '0;
                    if (in_reg.action == sca_pkg::ACT_FREE)
                    begin
                        res_reg   <= '{status: sca_pkg::ST_NOT_POOL, chunk_address: '0,
                                       page_taken: 1'b0, size_class: '0};
                        state_reg <= free_out ? S_RESULT : S_OWN_WAIT;
                    end
                    else if (size_zero)
                    begin
                        res_reg   <= '{status: sca_pkg::ST_ZERO_SIZE, chunk_address: '0,
                                       page_taken: 1'b0, size_class: '0};
                        state_reg <= S_RESULT;
                    end
                    else if (size_big)
                    begin
                        res_reg   <= '{status: sca_pkg::ST_TOO_LARGE, chunk_address: '0,
                                       page_taken: 1'b0, size_class: '0};
                        state_reg <= S_RESULT;
                    end
                    else if (!head_sel[LW-1])
                    begin
                        state_reg <= S_POP_WAIT;
                    end
                    else if (!spare_ok)
                    begin
                        res_reg   <= '{status: sca_pkg::ST_NO_PAGE, chunk_address: '0,
                                       page_taken: 1'b0, size_class: cls_dec};
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_FILL;
                    end
                end
                S_POP_WAIT:
                begin
                    // head moves on to the popped chunk's successor
                    head_reg[cls_reg] <= link_rd_data;
                    res_reg <= '{status: sca_pkg::ST_ALLOCATED, chunk_address: pop_addr,
                                 page_taken: 1'b0, size_class: cls_reg};
                    state_reg <= S_RESULT;
                end
                S_OWN_WAIT:
                begin
                    if (owner_valid)
                    begin
                        head_reg[owner_cls] <= {1'b0, slot_reg};
                        res_reg <= '{status: sca_pkg::ST_FREED, chunk_address: '0,
                                     page_taken: 1'b0, size_class: owner_cls};
                    end
                    state_reg <= S_RESULT;
                end
                S_FILL:
                begin
                    cur_reg      <= {1'b0, fill_slot};
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                    if (fill_last)
                    begin
                        // highest chunk is handed out, its link becomes the head
                        head_reg[cls_reg] <= cur_reg;
                        res_reg <= '{status: sca_pkg::ST_ALLOCATED, chunk_address: fill_addr,
                                     page_taken: 1'b1, size_class: cls_reg};
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res_data  = res_reg;

endmodule

// File: rtl/size_class_chunk_allocator_unit.sv
// ----------------------------------------------------------------------------
// size_class_chunk_allocator_unit - segregated-fit chunk allocator
// Flow: a request is registered and decoded; a pop or an in-pool free then waits
//   on a RAM read, a refill slices the page, and a rejected request goes straight
//   to the result; the response register adds no wait while rsp.ready is high.
// Throughput: one request in flight; the next is taken only after the result
//   has passed to the response register. The refill slices one chunk per
//   cycle through the single link RAM write port.
// Reset: list heads empty; a clearing pass over all PAGES pages marks every
//   page unowned, during which no request is taken. Link RAM is not initialised.
// ----------------------------------------------------------------------------
module size_class_chunk_allocator_unit #(
    parameter int PAGES = sca_pkg::DEF_PAGES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [sca_pkg::ADDR_W-1:0] cfg_wr_data,
    sca_req_if.sink                    req,
    sca_rsp_if.source                  rsp
);

    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SW = PW + sca_pkg::OFFS_W;
    localparam int LW = SW + 1;

    logic                      res_valid;
    logic                      res_ready;
    sca_pkg::rsp_t             res_data;
    logic                      in_ready;

    logic                      link_wr_en;
    logic [SW-1:0]             link_wr_addr;
    logic [LW-1:0]             link_wr_data;
    logic                      link_rd_en;
    logic [SW-1:0]             link_rd_addr;
    logic [LW-1:0]             link_rd_data;

    logic                      owner_wr_en;
    logic [PW-1:0]             owner_wr_addr;
    logic [sca_pkg::OWN_W-1:0] owner_wr_data;
    logic                      owner_rd_en;
    logic [PW-1:0]             owner_rd_addr;
    logic [sca_pkg::OWN_W-1:0] owner_rd_data;

    logic                      out_valid_reg;
    sca_pkg::rsp_t             out_data_reg;

    // Sequencer
    sca_ctrl #(
        .PAGES (PAGES),
        .PW    (PW),
        .SW    (SW),
        .LW    (LW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (req.valid),
        .in_ready      (in_ready),
        .in_data       (req.payload),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data),
        .link_wr_en    (link_wr_en),
        .link_wr_addr  (link_wr_addr),
        .link_wr_data  (link_wr_data),
        .link_rd_en    (link_rd_en),
        .link_rd_addr  (link_rd_addr),
        .link_rd_data  (link_rd_data),
        .owner_wr_en   (owner_wr_en),
        .owner_wr_addr (owner_wr_addr),
        .owner_wr_data (owner_wr_data),
        .owner_rd_en   (owner_rd_en),
        .owner_rd_addr (owner_rd_addr),
        .owner_rd_data (owner_rd_data)
    );

    // Next-free link per 16-byte slot
    sca_ram #(
        .DEPTH (PAGES * (1 << sca_pkg::OFFS_W)),
        .WIDTH (LW),
        .AW    (SW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    // Owning class per page
    sca_ram #(
        .DEPTH (PAGES),
        .WIDTH (sca_pkg::OWN_W),
        .AW    (PW)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (owner_wr_en),
        .wr_addr (owner_wr_addr),
        .wr_data (owner_wr_data),
        .rd_en   (owner_rd_en),
        .rd_addr (owner_rd_addr),
        .rd_data (owner_rd_data)
    );

    // Output register: frees the sequencer while a response waits
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign req.ready   = in_ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

`ifndef SYNTHESIS
    // A response handed over by the sequencer appears unchanged at the port
    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> rsp.valid && (rsp.payload == $past(res_data)))
        else $error("response register lost or altered a result");

    // One request in flight: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in progress");

    // A result never leaves the sequencer straight after a request transfer
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !res_valid)
        else $error("result raised before the request was decoded");
`endif

endmodule
